[rtl/core/lla_pkg.sv]
// Package for the life-like automaton step block: payload structs, codes,
// controller states and shared constants. No dependencies.
package lla_pkg;

    localparam int unsigned FULL_HISTORY = 256;
    localparam int unsigned TALLY_MAX    = 8191;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_RUN   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_BIRTH   = 3'd0,
        REG_SURVIVE = 3'd1,
        REG_ROWRAD  = 3'd2,
        REG_COLRAD  = 3'd3,
        REG_DECAY   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] cell_row;
        logic [5:0] cell_col;
        logic [8:0] history_in;
        logic [7:0] generation_count;
    } in_item_t;

    typedef struct packed {
        logic        cell_alive;
        logic [8:0]  cell_history;
        logic [12:0] births;
        logic [12:0] deaths;
        logic [12:0] live_count;
        logic [31:0] generation;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL_RD,
        ST_CELL_WAIT,
        ST_CELL_DONE,
        ST_GEN_START,
        ST_GEN_LOAD,
        ST_GEN_LOAD_WAIT,
        ST_GEN_CELL,
        ST_GEN_CELL_WAIT,
        ST_GEN_COMMIT,
        ST_GEN_END,
        ST_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clr_step;      // write zero at sweep address, advance
        logic cell_read;     // issue read at addressed cell
        logic cell_write;    // write history_in at addressed cell
        logic cell_latch;    // latch read data into result
        logic gen_start;     // reset sweep counter and tallies
        logic load_write;    // place read bit into staging grid, advance
        logic cell_rd;       // issue neighbor and history read at sweep cell
        logic cell_upd;      // compute and write back cell, advance
        logic gen_end;       // commit tallies and counter
        logic run_latch;     // clear cell fields of result
    } cmd_t;

    typedef struct packed {
        logic sweep_last;    // sweep address at last cell
        logic nbr_last;      // last neighbor offset of a cell
    } stat_t;

endpackage

[rtl/core/life_like_automaton_step.sv]
// Top level of the life-like automaton step block: config registers,
// controller and datapath. Depends on lla_pkg, lla_ctrl, lla_datapath.
//
//  channel  direction  handshake               payload
//  in       input      in_valid / in_ready     lla_pkg::in_item_t
//  out      output     out_valid / out_ready   lla_pkg::out_item_t
//  cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Cell write or read: states CELL_RD, CELL_WAIT and CELL_DONE, then the result transaction.
// Run of G generations: per generation a snapshot load pass over all cells, then a sweep
// that reads each cell's neighbors in turn through the snapshot memory port and writes back.
// After reset a clearing pass over all cells runs before any input is taken.
// A stalled result holds the block; configuration is always taken.
module life_like_automaton_step #(
    parameter int GRID_ROWS  = 64,
    parameter int GRID_COLS  = 64,
    parameter int MAX_RADIUS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lla_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lla_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import lla_pkg::*;

    logic [63:0] birth_reg, survive_reg;
    logic [1:0]  rowrad_reg, colrad_reg;
    logic [8:0]  decay_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            birth_reg <= 64'd8; survive_reg <= 64'd12;
            rowrad_reg <= 2'd1; colrad_reg <= 2'd1; decay_reg <= 9'd256;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_BIRTH:   birth_reg   <= cfg_data;
                REG_SURVIVE: survive_reg <= cfg_data;
                REG_ROWRAD:  rowrad_reg  <= cfg_data[1:0];
                REG_COLRAD:  colrad_reg  <= cfg_data[1:0];
                REG_DECAY:   decay_reg   <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    cmd_t     cmd;
    stat_t    stat;
    in_item_t item;

    lla_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .cmd(cmd), .stat(stat), .item(item));

    lla_datapath #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS),
                   .MAX_RADIUS(MAX_RADIUS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .item(item),
        .birth_mask(birth_reg), .survive_mask(survive_reg),
        .row_radius(rowrad_reg), .col_radius(colrad_reg),
        .decay_rate(decay_reg), .result(out_data));
endmodule

[rtl/core/lla_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module lla_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/lla_datapath.sv]
// Datapath of the life-like automaton step block: grid memories, neighbor
// counting, rule and history update, tallies. Depends on lla_pkg, lla_ram.
module lla_datapath #(
    parameter int GRID_ROWS  = 64,
    parameter int GRID_COLS  = 64,
    parameter int MAX_RADIUS = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lla_pkg::cmd_t     cmd,
    output lla_pkg::stat_t    stat,
    input  lla_pkg::in_item_t item,
    input  logic [63:0]       birth_mask,
    input  logic [63:0]       survive_mask,
    input  logic [1:0]        row_radius,
    input  logic [1:0]        col_radius,
    input  logic [8:0]        decay_rate,
    output lla_pkg::out_item_t result
);
    import lla_pkg::*;

    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CW    = $clog2(GRID_COLS);
    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = $clog2(2 * MAX_RADIUS + 1) + 1;
    localparam logic [1:0] RMAX = 2'(MAX_RADIUS);

    // sweep position
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [DW-1:0] dr_reg, dc_reg;   // neighbor offsets, 0 .. 2r
    logic [5:0]    nsum_reg;
    logic [12:0]   born_reg, died_reg, live_reg;
    logic [12:0]   births_reg, deaths_reg, lives_reg;
    logic [31:0]   gen_reg;
    logic          self_reg;
    logic          cell_alive_reg;
    logic [8:0]    cell_hist_reg;

    logic [1:0] rr, cr;
    assign rr = (row_radius > RMAX) ? RMAX : row_radius;
    assign cr = (col_radius > RMAX) ? RMAX : col_radius;

    logic [AW-1:0] sweep_addr;
    assign sweep_addr = AW'(row_reg) * AW'(GRID_COLS) + AW'(col_reg);

    // wrapped neighbor coordinates
    logic [RW+2:0] nr_w;
    logic [CW+2:0] nc_w;
    logic [RW-1:0] nr;
    logic [CW-1:0] nc;
    always_comb
    begin
        nr_w = (RW+3)'(row_reg) + (RW+3)'(GRID_ROWS) + (RW+3)'(dr_reg) - (RW+3)'(rr);
        nc_w = (CW+3)'(col_reg) + (CW+3)'(GRID_COLS) + (CW+3)'(dc_reg) - (CW+3)'(cr);
        if (nr_w >= (RW+3)'(2 * GRID_ROWS))
            nr = RW'(nr_w - (RW+3)'(2 * GRID_ROWS));
        else if (nr_w >= (RW+3)'(GRID_ROWS))
            nr = RW'(nr_w - (RW+3)'(GRID_ROWS));
        else
            nr = RW'(nr_w);
        if (nc_w >= (CW+3)'(2 * GRID_COLS))
            nc = CW'(nc_w - (CW+3)'(2 * GRID_COLS));
        else if (nc_w >= (CW+3)'(GRID_COLS))
            nc = CW'(nc_w - (CW+3)'(GRID_COLS));
        else
            nc = CW'(nc_w);
    end
    logic [AW-1:0] nbr_addr;
    assign nbr_addr = AW'(nr) * AW'(GRID_COLS) + AW'(nc);

    logic [AW-1:0] cell_addr;
    assign cell_addr = AW'(RW'(item.cell_row)) * AW'(GRID_COLS) + AW'(CW'(item.cell_col));

    logic [8:0] hin_sat;
    assign hin_sat = (item.history_in > 9'(FULL_HISTORY)) ? 9'(FULL_HISTORY) : item.history_in;

    // memories: cur (alive, current), snap (alive snapshot), hist
    logic          cur_we, snap_we, hist_we;
    logic [AW-1:0] cur_wa, cur_ra, snap_wa, snap_ra, hist_wa, hist_ra;
    logic          cur_wd, snap_wd, cur_rd, snap_rd;
    logic [8:0]    hist_wd, hist_rd;

    lla_ram #(.WIDTH(1), .DEPTH(CELLS)) u_cur (
        .clk(clk), .we(cur_we), .waddr(cur_wa), .wdata(cur_wd),
        .raddr(cur_ra), .rdata(cur_rd));
    lla_ram #(.WIDTH(1), .DEPTH(CELLS)) u_snap (
        .clk(clk), .we(snap_we), .waddr(snap_wa), .wdata(snap_wd),
        .raddr(snap_ra), .rdata(snap_rd));
    lla_ram #(.WIDTH(9), .DEPTH(CELLS)) u_hist (
        .clk(clk), .we(hist_we), .waddr(hist_wa), .wdata(hist_wd),
        .raddr(hist_ra), .rdata(hist_rd));

    logic          nbr_valid_reg;   // a neighbor read landed this cycle
    logic          nbr_self_reg;
    logic          last_issue;
    assign last_issue = (dr_reg == DW'({rr, 1'b0})) && (dc_reg == DW'({cr, 1'b0}));
    assign stat = '{sweep_last: (row_reg == RW'(GRID_ROWS - 1)) &&
                                (col_reg == CW'(GRID_COLS - 1)),
                    nbr_last: last_issue};

    // rule evaluation on full neighbor sum
    logic [5:0]  nfull, n;
    logic        self_now, born, died, alive_new;
    logic [16:0] prod;
    logic [8:0]  decay_sat, hist_new;
    always_comb
    begin
        nfull = nsum_reg + ((nbr_valid_reg && snap_rd) ? 6'd1 : 6'd0);
        // the own cell may be the read landing now (both radii zero)
        self_now = nbr_self_reg ? snap_rd : self_reg;
        n     = nfull - {5'd0, self_now};
        born  = !self_now && birth_mask[n];
        died  = self_now && !survive_mask[n];
        alive_new = born || (self_now && !died);
        decay_sat = (decay_rate > 9'(FULL_HISTORY)) ? 9'(FULL_HISTORY) : decay_rate;
        prod  = 17'(hist_rd) * 17'(9'(FULL_HISTORY) - decay_sat);
        if (born)
            hist_new = 9'(FULL_HISTORY);
        else if (!alive_new)
            hist_new = prod[16:8];
        else
            hist_new = hist_rd;
    end

    always_comb
    begin
        cur_we = 1'b0; cur_wa = sweep_addr; cur_wd = 1'b0; cur_ra = sweep_addr;
        snap_we = 1'b0; snap_wa = sweep_addr; snap_wd = cur_rd; snap_ra = nbr_addr;
        hist_we = 1'b0; hist_wa = sweep_addr; hist_wd = 9'd0; hist_ra = sweep_addr;
        if (cmd.clr_step)
        begin
            cur_we = 1'b1; hist_we = 1'b1;
        end
        if (cmd.cell_read)
        begin
            cur_ra = cell_addr; hist_ra = cell_addr;
        end
        if (cmd.cell_write)
        begin
            cur_we = 1'b1; cur_wa = cell_addr; cur_wd = (hin_sat == 9'(FULL_HISTORY));
            hist_we = 1'b1; hist_wa = cell_addr; hist_wd = hin_sat;
        end
        if (cmd.load_write)
            snap_we = 1'b1;
        if (cmd.cell_upd)
        begin
            cur_we = 1'b1; cur_wd = alive_new;
            hist_we = 1'b1; hist_wd = hist_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0; col_reg <= '0; dr_reg <= '0; dc_reg <= '0;
            nsum_reg <= '0; self_reg <= 1'b0; nbr_valid_reg <= 1'b0; nbr_self_reg <= 1'b0;
            born_reg <= '0; died_reg <= '0; live_reg <= '0;
            births_reg <= '0; deaths_reg <= '0; lives_reg <= '0; gen_reg <= '0;
            cell_alive_reg <= 1'b0; cell_hist_reg <= '0;
        end
        else
        begin
            nbr_valid_reg <= cmd.cell_rd;
            nbr_self_reg  <= cmd.cell_rd && (dr_reg == DW'(rr)) && (dc_reg == DW'(cr));
            if (cmd.cell_upd)
            begin
                dr_reg <= '0; dc_reg <= '0; nsum_reg <= '0; self_reg <= 1'b0;
                if (born && born_reg != 13'(TALLY_MAX)) born_reg <= born_reg + 13'd1;
                if (died && died_reg != 13'(TALLY_MAX)) died_reg <= died_reg + 13'd1;
                if (alive_new && live_reg != 13'(TALLY_MAX)) live_reg <= live_reg + 13'd1;
            end
            else
            begin
                if (nbr_valid_reg)
                begin
                    nsum_reg <= nfull;
                    if (nbr_self_reg)
                        self_reg <= snap_rd;
                end
                if (cmd.cell_rd)
                begin
                    // advance neighbor offsets column-first
                    if (dc_reg == DW'({cr, 1'b0}))
                    begin
                        dc_reg <= '0;
                        if (dr_reg != DW'({rr, 1'b0}))
                            dr_reg <= dr_reg + DW'(1);
                    end
                    else
                        dc_reg <= dc_reg + DW'(1);
                end
            end
            if (cmd.gen_start)
            begin
                row_reg <= '0; col_reg <= '0;
                born_reg <= '0; died_reg <= '0; live_reg <= '0;
            end
            if (cmd.clr_step || cmd.load_write || cmd.cell_upd)
            begin
                if (col_reg == CW'(GRID_COLS - 1))
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == RW'(GRID_ROWS - 1)) ? '0 : row_reg + RW'(1);
                end
                else
                    col_reg <= col_reg + CW'(1);
            end
            if (cmd.gen_end)
            begin
                births_reg <= born_reg; deaths_reg <= died_reg; lives_reg <= live_reg;
                gen_reg <= gen_reg + 32'd1;
            end
            if (cmd.cell_latch)
            begin
                cell_alive_reg <= cur_rd; cell_hist_reg <= hist_rd;
            end
            if (cmd.run_latch)
            begin
                cell_alive_reg <= 1'b0; cell_hist_reg <= '0;
            end
        end
    end

    assign result = '{cell_alive: cell_alive_reg, cell_history: cell_hist_reg,
                      births: births_reg, deaths: deaths_reg,
                      live_count: lives_reg, generation: gen_reg};

    a_self_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cell_upd |=> (nsum_reg == 6'd0 && dr_reg == '0 && dc_reg == '0))
        else $error("neighbor accumulator not cleared after update");
    a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (born_reg <= 13'(TALLY_MAX)) && (live_reg <= 13'(TALLY_MAX)))
        else $error("tally out of range");
    a_gen_inc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gen_end |=> gen_reg == $past(gen_reg) + 32'd1)
        else $error("generation counter did not advance");
endmodule

[rtl/core/lla_ctrl.sv]
// Controller of the life-like automaton step block: sequences clear, cell
// access and generation sweeps. Depends on lla_pkg.
module lla_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lla_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lla_pkg::cmd_t      cmd,
    input  lla_pkg::stat_t     stat,
    output lla_pkg::in_item_t  item
);
    import lla_pkg::*;

    state_t    state_reg, state_next;
    in_item_t  item_reg, item_next;
    logic [7:0] left_reg, left_next;

    assign item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        left_next  = left_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next = in_data;
                    left_next = in_data.generation_count;
                    case (op_t'(in_data.operation))
                        OP_WRITE, OP_READ: state_next = ST_CELL_RD;
                        OP_RUN:            state_next = ST_GEN_START;
                        default:           state_next = ST_GEN_END;
                    endcase
                end
            end
            ST_CELL_RD:
            begin
                if (op_t'(item_reg.operation) == OP_WRITE)
                    cmd.cell_write = 1'b1;
                state_next = ST_CELL_WAIT;
            end
            ST_CELL_WAIT:
            begin
                cmd.cell_read = 1'b1;
                state_next = ST_CELL_DONE;
            end
            ST_CELL_DONE:
            begin
                cmd.cell_latch = 1'b1;
                state_next = ST_OUT;
            end
            ST_GEN_START:
            begin
                if (left_reg == 8'd0)
                    state_next = ST_GEN_END;
                else
                begin
                    cmd.gen_start = 1'b1;
                    state_next = ST_GEN_LOAD;
                end
            end
            ST_GEN_LOAD:
            begin
                // current alive bit at the sweep address is read here
                state_next = ST_GEN_LOAD_WAIT;
            end
            ST_GEN_LOAD_WAIT:
            begin
                // snapshot the current alive bit into the neighbor grid
                cmd.load_write = 1'b1;
                state_next = stat.sweep_last ? ST_GEN_CELL : ST_GEN_LOAD;
            end
            ST_GEN_CELL:
            begin
                cmd.cell_rd = 1'b1;
                if (stat.nbr_last)
                    state_next = ST_GEN_CELL_WAIT;
            end
            ST_GEN_CELL_WAIT:
            begin
                cmd.cell_upd = 1'b1;
                if (stat.sweep_last)
                begin
                    left_next  = left_reg - 8'd1;
                    state_next = ST_GEN_COMMIT;
                end
                else
                    state_next = ST_GEN_CELL;
            end
            ST_GEN_COMMIT:
            begin
                cmd.gen_end = 1'b1;
                state_next = (left_reg == 8'd0) ? ST_GEN_END : ST_GEN_START;
            end
            ST_GEN_END:
            begin
                cmd.run_latch = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_out_only_idle_next: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> state_reg == ST_IDLE)
        else $error("result transaction did not return to idle");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input accepted while result pending");
    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> state_reg == ST_CLEAR)
        else $error("clearing pass skipped");
endmodule

[tb/tb.sv]
// Self-checking testbench for life_like_automaton_step: cell writes, reads and
// generation runs checked against an in-bench predictor of the toroidal grid.
// Depends on lla_pkg and the life_like_automaton_step RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lla_pkg::*;

    localparam int ROWS = 64;
    localparam int COLS = 64;
    localparam int CELLS = ROWS * COLS;
    localparam int MAX_RAD = 3;
    localparam int STALL_LIMIT = 2000000;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    life_like_automaton_step dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // grid model and its configuration
    logic [63:0] birth_rule = 64'd8;
    logic [63:0] survive_rule = 64'd12;
    logic [1:0] rad_rows = 2'd1;
    logic [1:0] rad_cols = 2'd1;
    logic [8:0] decay = 9'd256;
    bit alive_grid [CELLS];
    logic [8:0] history_grid [CELLS];
    logic [5:0] col_window [CELLS];
    logic [31:0] gen_total = '0;
    logic [12:0] born_last = '0;
    logic [12:0] died_last = '0;
    logic [12:0] live_last = '0;

    in_item_t pending_items [$];
    out_item_t expected_results [$];
    bit in_hold = 1'b0;
    int send_idle_pct = 25;
    int recv_stall_pct = 62;
    int mismatches = 0;
    int results_seen = 0;
    int items_sent = 0;
    int gens_run = 0;
    int stall_cycles = 0;

    function automatic logic [8:0] decayed(logic [8:0] h);
        int d;
        d = (decay > 9'd256) ? 256 : int'(decay);
        return 9'((int'(h) * (256 - d)) >> 8);
    endfunction

    function automatic logic [12:0] bump(logic [12:0] t);
        return (t < 13'd8191) ? t + 13'd1 : t;
    endfunction

    function automatic void step_generation();
        int rr;
        int cr;
        int s;
        int n;
        int idx;
        logic [12:0] born;
        logic [12:0] died;
        logic [12:0] live;
        rr = (rad_rows > MAX_RAD) ? MAX_RAD : int'(rad_rows);
        cr = (rad_cols > MAX_RAD) ? MAX_RAD : int'(rad_cols);
        born = '0;
        died = '0;
        live = '0;
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
            begin
                s = 0;
                for (int k = 0; k <= 2 * rr; k++)
                    s += alive_grid[((r + ROWS + k - rr) % ROWS) * COLS + c];
                col_window[r * COLS + c] = 6'(s);
            end
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
            begin
                idx = r * COLS + c;
                n = 0;
                for (int k = 0; k <= 2 * cr; k++)
                    n += col_window[r * COLS + (c + COLS + k - cr) % COLS];
                n = (n - int'(alive_grid[idx])) & 63;
                if (!alive_grid[idx])
                begin
                    if (birth_rule[n])
                    begin
                        alive_grid[idx] = 1'b1;
                        history_grid[idx] = 9'd256;
                        born = bump(born);
                    end
                    else
                        history_grid[idx] = decayed(history_grid[idx]);
                end
                else if (!survive_rule[n])
                begin
                    alive_grid[idx] = 1'b0;
                    history_grid[idx] = decayed(history_grid[idx]);
                    died = bump(died);
                end
                if (alive_grid[idx])
                    live = bump(live);
            end
        born_last = born;
        died_last = died;
        live_last = live;
        gen_total = gen_total + 32'd1;
        gens_run++;
    endfunction

    function automatic out_item_t predict_result(in_item_t it);
        out_item_t res;
        int idx;
        logic [8:0] h;
        res = '0;
        idx = int'(it.cell_row) * COLS + int'(it.cell_col);
        case (op_t'(it.operation))
            OP_WRITE:
            begin
                h = (it.history_in > 9'd256) ? 9'd256 : it.history_in;
                history_grid[idx] = h;
                alive_grid[idx] = (h == 9'd256);
                res.cell_alive = alive_grid[idx];
                res.cell_history = history_grid[idx];
            end
            OP_READ:
            begin
                res.cell_alive = alive_grid[idx];
                res.cell_history = history_grid[idx];
            end
            OP_RUN:
                for (int g = 0; g < int'(it.generation_count); g++)
                    step_generation();
            default: ;
        endcase
        res.births = born_last;
        res.deaths = died_last;
        res.live_count = live_last;
        res.generation = gen_total;
        return res;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (!in_hold && pending_items.size() > 0
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data <= pending_items.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
        out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);

    // monitor and scoreboard
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction %p", out_data);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.cell_alive !== want.cell_alive
                        || out_data.cell_history !== want.cell_history
                        || out_data.births !== want.births
                        || out_data.deaths !== want.deaths
                        || out_data.live_count !== want.live_count
                        || out_data.generation !== want.generation)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at %0t: expected %p got %p",
                                     $realtime, want, out_data);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                items_sent++;
                expected_results.push_back(predict_result(in_data));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] index, logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            REG_BIRTH: birth_rule = value;
            REG_SURVIVE: survive_rule = value;
            REG_ROWRAD: rad_rows = value[1:0];
            REG_COLRAD: rad_cols = value[1:0];
            REG_DECAY: decay = value[8:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_hold = 1'b0;
        do @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        in_hold = 1'b1;
        repeat (8) @(negedge clk);
    endtask

    task automatic add_item(op_t op, int row, int col, int hist, int gens);
        in_item_t it;
        it.operation = op;
        it.cell_row = 6'(row);
        it.cell_col = 6'(col);
        it.history_in = 9'(hist);
        it.generation_count = 8'(gens);
        pending_items.push_back(it);
    endtask

    // random items clustered around the wrap corner so cells interact
    task automatic add_random(int count);
        int roll;
        int row;
        int col;
        int hist;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 7)
            begin
                row = (60 + $urandom_range(0, 7)) & 63;
                col = (60 + $urandom_range(0, 7)) & 63;
            end
            else
            begin
                row = $urandom_range(0, 63);
                col = $urandom_range(0, 63);
            end
            case ($urandom_range(0, 9))
                0, 1: hist = $urandom_range(0, 255);
                2: hist = $urandom_range(257, 511);
                default: hist = 256;
            endcase
            if (roll < 55)
                add_item(OP_WRITE, row, col, hist, $urandom_range(0, 255));
            else if (roll < 88)
                add_item(OP_READ, row, col, hist, $urandom_range(0, 255));
            else if (roll < 94)
                add_item(OP_NONE, row, col, hist, $urandom_range(0, 255));
            else
                add_item(OP_RUN, row, col, hist, $urandom_range(0, 1));
        end
    endtask

    initial
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            alive_grid[i] = 1'b0;
            history_grid[i] = '0;
        end
        in_hold = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: blinker across the corner wrap, saturation, decay, no-ops
        add_item(OP_READ, 0, 0, 0, 0);
        add_item(OP_WRITE, 63, 62, 256, 0);
        add_item(OP_WRITE, 63, 63, 300, 255);
        add_item(OP_WRITE, 63, 0, 511, 0);
        add_item(OP_WRITE, 5, 5, 255, 0);
        add_item(OP_READ, 5, 5, 0, 0);
        add_item(OP_WRITE, 10, 10, 0, 0);
        add_item(OP_NONE, 63, 63, 511, 255);
        add_item(OP_RUN, 0, 0, 0, 0);
        add_item(OP_RUN, 63, 63, 511, 1);
        add_item(OP_READ, 62, 63, 0, 0);
        add_item(OP_READ, 63, 63, 0, 0);
        add_item(OP_READ, 0, 63, 0, 0);
        add_item(OP_READ, 63, 62, 0, 0);
        add_item(OP_READ, 5, 5, 0, 0);
        add_item(OP_RUN, 0, 0, 0, 2);
        add_item(OP_READ, 63, 0, 511, 255);
        add_item(OP_WRITE, 0, 63, 128, 170);
        add_item(OP_READ, 42, 21, 85, 85);
        drain();

        write_reg(REG_BIRTH, {$urandom, $urandom} | 64'd8);
        write_reg(REG_SURVIVE, {$urandom, $urandom});
        write_reg(REG_ROWRAD, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_COLRAD, 64'h0);
        write_reg(REG_DECAY, 64'd128);
        send_idle_pct = 25;
        recv_stall_pct = 62;
        add_random(40);
        drain();

        write_reg(REG_BIRTH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_SURVIVE, 64'h0);
        write_reg(REG_ROWRAD, 64'h0);
        write_reg(REG_COLRAD, 64'd3);
        write_reg(REG_DECAY, 64'h0);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        send_idle_pct = 62;
        recv_stall_pct = 25;
        add_random(40);
        drain();

        write_reg(REG_BIRTH, {$urandom, $urandom});
        write_reg(REG_SURVIVE, {$urandom, $urandom});
        write_reg(REG_ROWRAD, 64'd3);
        write_reg(REG_COLRAD, 64'd2);
        write_reg(REG_DECAY, 64'h1FF);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_random(40);
        drain();

        repeat (50) @(posedge clk);
        $display("covered %0d item transactions and %0d results over %0d generations",
                 items_sent, results_seen, gens_run);
        $display("four rule settings, radii 0 to 3, decay none to saturated, wrap corner");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[life_like_automaton_step.f]
rtl/core/lla_pkg.sv
rtl/core/lla_ram.sv
rtl/core/lla_datapath.sv
rtl/core/lla_ctrl.sv
rtl/core/life_like_automaton_step.sv
tb/tb.sv
